// File: rtl/core/tmbc_pkg.sv
// Shared constants, codes and helper functions of the tile map box collision unit.
`default_nettype none

package tmbc_pkg;

  localparam int TILE_PIXELS = 8;
  localparam int TILE_SHIFT  = $clog2(TILE_PIXELS);
  localparam int MAX_COLUMNS = 32;
  localparam int MAX_ROWS    = 32;
  localparam int STORE_DEPTH = MAX_COLUMNS * MAX_ROWS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CODE_W      = 8;
  localparam int DIM_W       = 6;

  // tile coordinates and pixel sums, signed, with headroom
  localparam int COORD_W = 12;
  localparam int IDX_W   = COORD_W + DIM_W + 2;
  localparam int LIM_W   = 2 * DIM_W + 1;

  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 48;

  // transfer kinds on s_tuser
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // register indexes
  localparam logic [3:0] REG_MAP_COLUMNS = 4'd0;
  localparam logic [3:0] REG_MAP_ROWS    = 4'd1;
  localparam logic [3:0] REG_SOLID_FIRST = 4'd2;
  localparam logic [3:0] REG_SOLID_LAST  = 4'd3;
  localparam logic [3:0] REG_PLAT_FIRST  = 4'd4;
  localparam logic [3:0] REG_PLAT_LAST   = 4'd5;
  localparam logic [3:0] REG_SIDE_FIRST  = 4'd6;
  localparam logic [3:0] REG_SIDE_LAST   = 4'd7;

  // divide by the tile size, truncating toward zero
  function automatic logic signed [COORD_W-1:0] tile_div(input logic signed [COORD_W-1:0] v);
    logic signed [COORD_W-1:0] n;
    n = -v;
    if (v[COORD_W-1]) tile_div = -(n >>> TILE_SHIFT);
    else tile_div = v >>> TILE_SHIFT;
  endfunction

  function automatic logic [8:0] sat9(input logic signed [COORD_W-1:0] v);
    if (v[COORD_W-1]) sat9 = 9'd0;
    else if (v > COORD_W'(511)) sat9 = 9'd511;
    else sat9 = v[8:0];
  endfunction

  function automatic logic in_range(input logic [CODE_W-1:0] c, input logic [CODE_W-1:0] lo,
                                    input logic [CODE_W-1:0] hi);
    in_range = (lo <= c) && (c <= hi);
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/tile_map_box_collision_unit.sv
// Top level of the tile map box collision unit: tile store, sequencer and result register.
//
// Channel | Dir | Handshake          | Contents
// s_*     | in  | s_tvalid/s_tready  | tuser: operation; tdata: write or query fields
// m_*     | out | m_tvalid/m_tready  | tdata: collision flags, snapped rows, span
// cfg_*   | in  | cfg_valid/cfg_ready| cfg_index: register, cfg_data: value
//
// A query walks the tile store one tile at a time, an address step and then a registered
// read and classify step per tile, through the single RAM read port:
// both edge columns, the ground, ceiling and floor rows, then the columns left and
// right for the span, stopping each row walk and span walk at the first hit.
// Empty row or column ranges and span walks reaching the map border skip the tile read.
// Reset (rst, synchronous) restores the registers; the tile store is not cleared.
// s_tready is low for the whole query; a finished result waits in the output register
// and the next transfer is taken while it is still pending. A query that finishes
// while the previous result is still waiting holds in the done state until it goes.
`default_nettype none

module tile_map_box_collision_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic        s_tuser,   // [0] operation
  // [9:0] tile_index, [17:10] tile_code, [26:18] box_x, [35:27] box_y,
  // [43:36] box_width, [51:44] box_height, [60:52] probe_y, rest zero
  input  wire logic [63:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [0] wall_left, [1] wall_right, [2] side_left, [3] side_right, [4] ground_hit,
  // [14:5] ground_y, [15] ceiling_hit, [26:16] ceiling_y, [27] falling,
  // [36:28] span_x, [45:37] span_width, rest zero
  output logic [47:0]      m_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  localparam int CW = tmbc_pkg::COORD_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_CK   = 3'd2;
  localparam logic [2:0] S_DONE = 3'd3;

  // query phases
  localparam logic [2:0] P_LEFT  = 3'd0;
  localparam logic [2:0] P_RIGHT = 3'd1;
  localparam logic [2:0] P_GND   = 3'd2;
  localparam logic [2:0] P_CEIL  = 3'd3;
  localparam logic [2:0] P_FALL  = 3'd4;
  localparam logic [2:0] P_SPL   = 3'd5;
  localparam logic [2:0] P_SPR   = 3'd6;

  // configuration
  logic [tmbc_pkg::DIM_W-1:0]  map_columns, map_rows;
  logic [tmbc_pkg::CODE_W-1:0] solid_lo, solid_hi, plat_lo, plat_hi;
  logic [tmbc_pkg::CODE_W-1:0] side_lo, side_hi;
  logic [tmbc_pkg::LIM_W-1:0]  lim, area;

  logic [2:0] state, state_next, phase, phase_next;
  logic signed [CW-1:0] cx, cx_next, cy, cy_next;
  logic signed [CW-1:0] x0, x1, y0, y1, gr, cr, ceil_trunc, fr;
  logic signed [CW-1:0] span_l, span_l_next, span_r, span_r_next;
  logic [8:0] py;
  logic wl, wl_next, wr, wr_next, sl, sl_next, sr, sr_next;
  logic gh, gh_next, ch, ch_next, fh, fh_next;
  logic in_map_q;
  logic [47:0] out_data;

  // tiles in the map, at full width
  assign area = tmbc_pkg::LIM_W'(map_columns) * tmbc_pkg::LIM_W'(map_rows);

  // input field views
  logic signed [CW-1:0] a_bx, a_by, a_bw, a_bh, a_py, a_c;
  assign a_bx = CW'(s_tdata[26:18]);
  assign a_by = CW'(s_tdata[35:27]);
  assign a_bw = CW'(s_tdata[43:36]);
  assign a_bh = CW'(s_tdata[51:44]);
  assign a_py = CW'(s_tdata[60:52]);
  assign a_c  = a_py - a_bh;

  logic in_acc;
  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = s_tvalid && s_tready;

  // linear index of the current tile, empty outside the map
  logic signed [tmbc_pkg::IDX_W-1:0] idx;
  logic in_map;
  assign idx = tmbc_pkg::IDX_W'(cx)
             + tmbc_pkg::IDX_W'(cy) * tmbc_pkg::IDX_W'({1'b0, map_columns});
  assign in_map = !idx[tmbc_pkg::IDX_W-1]
               && (idx[tmbc_pkg::IDX_W-2:0] < (tmbc_pkg::IDX_W-1)'(lim));

  logic [tmbc_pkg::CODE_W-1:0] rdata;

  tmbc_ram #(
    .WIDTH(tmbc_pkg::CODE_W),
    .DEPTH(tmbc_pkg::STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (in_acc && (s_tuser == tmbc_pkg::OP_WRITE)),
    .waddr(s_tdata[tmbc_pkg::ADDR_W-1:0]),
    .wdata(s_tdata[17:10]),
    .raddr(idx[tmbc_pkg::ADDR_W-1:0]),
    .rdata(rdata)
  );

  // tile classes of the read tile
  logic is_solid, is_side, is_floor;
  assign is_solid = in_map_q && tmbc_pkg::in_range(rdata, solid_lo, solid_hi);
  assign is_side  = in_map_q && tmbc_pkg::in_range(rdata, side_lo, side_hi);
  assign is_floor = is_solid
                 || (in_map_q && tmbc_pkg::in_range(rdata, plat_lo, plat_hi));

  logic col_phase, range_empty;
  logic signed [CW-1:0] cols_s;
  assign col_phase   = (phase == P_LEFT) || (phase == P_RIGHT)
                    || (phase == P_SPL) || (phase == P_SPR);
  assign range_empty = col_phase ? (y0 > y1) : (x0 > x1);
  assign cols_s      = CW'(map_columns);

  logic do_adv, at_end, h_solid, h_side, h_floor;

  always_comb begin
    state_next  = state;
    phase_next  = phase;
    cx_next     = cx;
    cy_next     = cy;
    span_l_next = span_l;
    span_r_next = span_r;
    wl_next = wl; wr_next = wr; sl_next = sl; sr_next = sr;
    gh_next = gh; ch_next = ch; fh_next = fh;
    do_adv  = 1'b0;
    at_end  = 1'b0;
    h_solid = 1'b0;
    h_side  = 1'b0;
    h_floor = 1'b0;
    case (state)
      S_RD: begin
        if ((phase == P_SPL) && cx[CW-1]) begin
          span_l_next = -CW'(1);
          phase_next  = P_SPR;
          cx_next     = x0 + CW'(1);
          cy_next     = y0;
        end else if ((phase == P_SPR) && (cx >= cols_s)) begin
          span_r_next = cx;
          state_next  = S_DONE;
        end else if (range_empty) begin
          do_adv = 1'b1;
          at_end = 1'b1;
        end else begin
          state_next = S_CK;
        end
      end
      S_CK: begin
        do_adv  = 1'b1;
        at_end  = col_phase ? (cy == y1) : (cx == x1);
        h_solid = is_solid;
        h_side  = is_side;
        h_floor = is_floor;
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) state_next = S_IDLE;
      end
      default: state_next = state;
    endcase

    if (do_adv) begin
      state_next = S_RD;
      case (phase)
        P_LEFT: begin
          wl_next = wl | h_solid;
          sl_next = sl | h_side;
          if (at_end) begin
            phase_next = P_RIGHT; cx_next = x1; cy_next = y0;
          end else cy_next = cy + CW'(1);
        end
        P_RIGHT: begin
          wr_next = wr | h_solid;
          sr_next = sr | h_side;
          if (at_end) begin
            phase_next = P_GND; cx_next = x0; cy_next = gr;
          end else cy_next = cy + CW'(1);
        end
        P_GND: begin
          gh_next = gh | h_floor;
          if (h_floor || at_end) begin
            phase_next = P_CEIL; cx_next = x0; cy_next = cr;
          end else cx_next = cx + CW'(1);
        end
        P_CEIL: begin
          ch_next = ch | h_floor;
          if (h_floor || at_end) begin
            phase_next = P_FALL; cx_next = x0; cy_next = fr;
          end else cx_next = cx + CW'(1);
        end
        P_FALL: begin
          fh_next = fh | h_floor;
          if (h_floor || at_end) begin
            phase_next = P_SPL; cx_next = x0 - CW'(1); cy_next = y0;
          end else cx_next = cx + CW'(1);
        end
        P_SPL: begin
          if (h_solid) begin
            span_l_next = cx;
            phase_next  = P_SPR; cx_next = x0 + CW'(1); cy_next = y0;
          end else if (at_end) begin
            cx_next = cx - CW'(1); cy_next = y0;
          end else cy_next = cy + CW'(1);
        end
        P_SPR: begin
          if (h_solid) begin
            span_r_next = cx;
            state_next  = S_DONE;
          end else if (at_end) begin
            cx_next = cx + CW'(1); cy_next = y0;
          end else cy_next = cy + CW'(1);
        end
        default: state_next = S_IDLE;
      endcase
    end
  end

  // result assembly
  logic signed [CW-1:0] sx, sw, gy_snap, cy_snap;
  always_comb begin
    sx      = (span_l + CW'(1)) <<< tmbc_pkg::TILE_SHIFT;
    sw      = (span_r <<< tmbc_pkg::TILE_SHIFT) - sx;
    gy_snap = (gr <<< tmbc_pkg::TILE_SHIFT) - CW'(1);
    cy_snap = (ceil_trunc <<< tmbc_pkg::TILE_SHIFT) + CW'(1);
    out_data = '0;
    out_data[0]     = wl;
    out_data[1]     = wr;
    out_data[2]     = sl;
    out_data[3]     = sr;
    out_data[4]     = gh;
    out_data[14:5]  = gh ? gy_snap[9:0] : {1'b0, py};
    out_data[15]    = ch;
    out_data[26:16] = ch ? cy_snap[10:0] : {2'b00, py};
    out_data[27]    = !fh;
    out_data[36:28] = tmbc_pkg::sat9(sx);
    out_data[45:37] = tmbc_pkg::sat9(sw);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      phase       <= P_LEFT;
      m_tvalid    <= 1'b0;
      map_columns <= tmbc_pkg::DIM_W'(32);
      map_rows    <= tmbc_pkg::DIM_W'(32);
      solid_lo    <= '0; solid_hi <= '0;
      plat_lo     <= '0; plat_hi  <= '0;
      side_lo     <= '0; side_hi  <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          tmbc_pkg::REG_MAP_COLUMNS: map_columns <= cfg_data[tmbc_pkg::DIM_W-1:0];
          tmbc_pkg::REG_MAP_ROWS:    map_rows    <= cfg_data[tmbc_pkg::DIM_W-1:0];
          tmbc_pkg::REG_SOLID_FIRST: solid_lo    <= cfg_data;
          tmbc_pkg::REG_SOLID_LAST:  solid_hi    <= cfg_data;
          tmbc_pkg::REG_PLAT_FIRST:  plat_lo     <= cfg_data;
          tmbc_pkg::REG_PLAT_LAST:   plat_hi     <= cfg_data;
          tmbc_pkg::REG_SIDE_FIRST:  side_lo     <= cfg_data;
          tmbc_pkg::REG_SIDE_LAST:   side_hi     <= cfg_data;
          default: ;
        endcase
      end
      if (in_acc && (s_tuser == tmbc_pkg::OP_QUERY)) begin
        state <= S_RD;
        phase <= P_LEFT;
      end else begin
        state <= state_next;
        phase <= phase_next;
      end
      if ((state == S_DONE) && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    // usable span of the store for this map shape
    if (area > tmbc_pkg::LIM_W'(tmbc_pkg::STORE_DEPTH))
      lim <= tmbc_pkg::LIM_W'(tmbc_pkg::STORE_DEPTH);
    else
      lim <= area;
    in_map_q <= in_map;
    if ((state == S_DONE) && (!m_tvalid || m_tready)) m_tdata <= out_data;
    if (in_acc && (s_tuser == tmbc_pkg::OP_QUERY)) begin
      x0         <= tmbc_pkg::tile_div(a_bx);
      x1         <= tmbc_pkg::tile_div(a_bx + a_bw - CW'(1));
      y0         <= tmbc_pkg::tile_div(a_by);
      y1         <= tmbc_pkg::tile_div(a_by + a_bh - CW'(1));
      gr         <= tmbc_pkg::tile_div(a_py);
      cr         <= tmbc_pkg::tile_div(a_c + CW'(1));
      ceil_trunc <= tmbc_pkg::tile_div(a_c);
      fr         <= tmbc_pkg::tile_div(a_by + a_bh);
      py         <= s_tdata[60:52];
      cx         <= tmbc_pkg::tile_div(a_bx);
      cy         <= tmbc_pkg::tile_div(a_by);
      wl <= 1'b0; wr <= 1'b0; sl <= 1'b0; sr <= 1'b0;
      gh <= 1'b0; ch <= 1'b0; fh <= 1'b0;
    end else begin
      cx <= cx_next;
      cy <= cy_next;
      span_l <= span_l_next;
      span_r <= span_r_next;
      wl <= wl_next; wr <= wr_next; sl <= sl_next; sr <= sr_next;
      gh <= gh_next; ch <= ch_next; fh <= fh_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/tmbc_ram.sv
// Generic single write port RAM with registered read.
`default_nettype none

module tmbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: dv/tb_tile_map_box_collision_unit.sv
// Self-checking testbench of the tile map box collision unit: tile loads, box queries, registers.
`timescale 1ns / 100ps

module tb_tile_map_box_collision_unit;

  // cycles allowed for the longest query walk before the block counts as idle
  localparam int SETTLE_CYCLES = 4000;
  localparam int HOLD_CYCLES   = 3000;
  localparam int CYCLE_LIMIT   = 4000000;
  localparam int RANDOM_ITEMS  = 650;

  // queued work for the driver: a stream item, a register write, or a wait for idle
  typedef enum logic [1:0] {K_ITEM, K_CFG, K_SETTLE} job_kind_t;

  typedef struct {
    job_kind_t   kind;
    logic        op;
    logic [63:0] data;
    logic [3:0]  ridx;
    logic [7:0]  rval;
  } job_t;

  // result layout as on m_tdata, lowest field last
  typedef struct packed {
    logic [8:0]  span_width;
    logic [8:0]  span_x;
    logic        falling;
    logic [10:0] ceiling_y;
    logic        ceiling_hit;
    logic [9:0]  ground_y;
    logic        ground_hit;
    logic        side_right;
    logic        side_left;
    logic        wall_right;
    logic        wall_left;
  } hit_report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic        s_tuser = 1'b0;
  logic [63:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;

  tile_map_box_collision_unit uut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tuser, .s_tdata,
    .m_tvalid, .m_tready, .m_tdata, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always #4 clk = ~clk;

  // shadow state of the block
  logic [7:0]  tiles [tmbc_pkg::STORE_DEPTH];
  logic [7:0]  regs [8];
  job_t        jobs[$];
  hit_report_t pending_reports[$];

  int cycles = 0;
  int mismatches = 0;
  int reports_seen = 0;
  bit s_took = 0;
  bit cfg_took = 0;

  // ---------------------------------------------------------------- predictor

  function automatic bit tile_in_class(int x, int y, int kind);
    int idx, lim, cols;
    logic [7:0] code;
    bit solid, plat;
    cols = int'(regs[tmbc_pkg::REG_MAP_COLUMNS][5:0]);
    idx  = x + y * cols;
    lim  = cols * int'(regs[tmbc_pkg::REG_MAP_ROWS][5:0]);
    if (lim > tmbc_pkg::STORE_DEPTH) lim = tmbc_pkg::STORE_DEPTH;
    if (idx < 0 || idx >= lim) return 0;   // outside the map reads as empty
    code  = tiles[idx];
    solid = regs[tmbc_pkg::REG_SOLID_FIRST] <= code && code <= regs[tmbc_pkg::REG_SOLID_LAST];
    plat  = regs[tmbc_pkg::REG_PLAT_FIRST] <= code && code <= regs[tmbc_pkg::REG_PLAT_LAST];
    if (kind == 0) return solid;
    if (kind == 1)
      return regs[tmbc_pkg::REG_SIDE_FIRST] <= code && code <= regs[tmbc_pkg::REG_SIDE_LAST];
    return solid || plat;
  endfunction

  function automatic bit column_hits(int x, int y0, int y1, int kind);
    for (int y = y0; y <= y1; y++)
      if (tile_in_class(x, y, kind)) return 1;
    return 0;
  endfunction

  function automatic bit row_hits(int y, int x0, int x1);
    for (int x = x0; x <= x1; x++)
      if (tile_in_class(x, y, 2)) return 1;
    return 0;
  endfunction

  function automatic logic [8:0] clamp9(int v);
    if (v < 0) return 9'd0;
    if (v > 511) return 9'd511;
    return v[8:0];
  endfunction

  function automatic hit_report_t predict_collision(logic [63:0] d);
    hit_report_t r;
    int bx, by, bw, bh, py, y0, y1, x0, x1, c, gy, cy, xl, xr, sx, tp;
    bit gh, ch;
    tp = tmbc_pkg::TILE_PIXELS;
    bx = int'(d[26:18]); by = int'(d[35:27]);
    bw = int'(d[43:36]); bh = int'(d[51:44]); py = int'(d[60:52]);
    // SV integer division truncates toward zero, as required for negative sums
    y0 = by / tp;
    y1 = (by + bh - 1) / tp;
    x0 = bx / tp;
    x1 = (bx + bw - 1) / tp;
    r.wall_left  = column_hits(x0, y0, y1, 0);
    r.wall_right = column_hits(x1, y0, y1, 0);
    r.side_left  = column_hits(x0, y0, y1, 1);
    r.side_right = column_hits(x1, y0, y1, 1);
    gh = row_hits(py / tp, x0, x1);
    gy = gh ? (py / tp) * tp - 1 : py;
    r.ground_hit = gh;
    r.ground_y   = gy[9:0];
    c  = py - bh;
    ch = row_hits((c + 1) / tp, x0, x1);
    cy = ch ? (c / tp) * tp + 1 : py;
    r.ceiling_hit = ch;
    r.ceiling_y   = cy[10:0];
    r.falling     = !row_hits((by + bh) / tp, x0, x1);
    // span between the nearest solid columns either side of the left edge column
    xl = x0 - 1;
    while (xl >= 0 && !column_hits(xl, y0, y1, 0)) xl--;
    sx = (xl + 1) * tp;
    xr = x0 + 1;
    while (xr < int'(regs[tmbc_pkg::REG_MAP_COLUMNS][5:0]) && !column_hits(xr, y0, y1, 0))
      xr++;
    r.span_x     = clamp9(sx);
    r.span_width = clamp9(xr * tp - sx);
    return r;
  endfunction

  // ---------------------------------------------------------------- monitor

  localparam int FIELD_LSB [11] = '{0, 1, 2, 3, 4, 5, 15, 16, 27, 28, 37};
  localparam int FIELD_W   [11] = '{1, 1, 1, 1, 1, 10, 1, 11, 1, 9, 9};
  string field_name [11] = '{"wall_left", "wall_right", "side_left", "side_right",
                             "ground_hit", "ground_y", "ceiling_hit", "ceiling_y",
                             "falling", "span_x", "span_width"};

  always @(posedge clk) begin
    logic [47:0] want, diff;
    logic [47:0] fmask;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_tile_map_box_collision_unit: FAIL");
      $finish;
    end else if (!rst) begin
      if (s_tvalid && s_tready) begin
        s_took = 1;
        if (s_tuser == tmbc_pkg::OP_WRITE) tiles[s_tdata[9:0]] = s_tdata[17:10];
        else pending_reports.push_back(predict_collision(s_tdata));
      end
      if (cfg_valid && cfg_ready) begin
        cfg_took = 1;
        regs[cfg_index[2:0]] = cfg_data;
      end
      if (m_tvalid && m_tready) begin
        reports_seen++;
        if (pending_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transfer %h", m_tdata);
        end else begin
          want = {2'b00, pending_reports.pop_front()};
          diff = want ^ m_tdata;
          if (diff[47:46] != 0) begin
            mismatches++;
            if (mismatches <= 10) $display("padding bits set: %h", m_tdata);
          end
          for (int f = 0; f < 11; f++) begin
            fmask = ((48'd1 << FIELD_W[f]) - 1) << FIELD_LSB[f];
            if ((diff & fmask) != 0) begin
              mismatches++;
              if (mismatches <= 10)
                $display("result %0d %s: expected %0h, got %0h", reports_seen, field_name[f],
                         (want & fmask) >> FIELD_LSB[f], (m_tdata & fmask) >> FIELD_LSB[f]);
            end
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- driver

  int burst = 8;
  int gap = 0;
  int settle_count = 0;

  always @(negedge clk) begin
    logic nv, cv;
    nv = s_tvalid;
    cv = cfg_valid;
    if (!rst) begin
      if (s_took) begin
        s_took = 0;
        void'(jobs.pop_front());
        nv = 0;
        burst--;
        if (burst <= 0) begin
          // new burst; sometimes back to back with no gap at all
          gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          burst = $urandom_range(1, 24);
        end
      end
      if (cfg_took) begin
        cfg_took = 0;
        void'(jobs.pop_front());
        cv = 0;
      end
      if (!nv && !cv && jobs.size() > 0) begin
        case (jobs[0].kind)
          K_ITEM: begin
            if (gap > 0) gap--;
            else begin
              nv = 1;
              s_tuser <= jobs[0].op;
              s_tdata <= jobs[0].data;
            end
          end
          K_CFG: begin
            cv = 1;
            cfg_index <= jobs[0].ridx;
            cfg_data  <= jobs[0].rval;
          end
          default: begin
            // sender holds off until every result is in, then lets the block settle
            if (pending_reports.size() == 0) begin
              if (settle_count >= SETTLE_CYCLES) begin
                settle_count = 0;
                void'(jobs.pop_front());
              end else settle_count++;
            end
          end
        endcase
      end
    end
    s_tvalid  <= nv;
    cfg_valid <= cv;
  end

  // ---------------------------------------------------------------- receiver

  bit hold = 0;
  bit hold_done = 0;
  int hold_count = 0;

  // one long stall of the result side while the sender keeps offering
  always @(negedge clk) begin
    if (!hold_done && reports_seen >= 40) begin
      if (hold_count < HOLD_CYCLES) begin
        hold <= 1;
        hold_count++;
      end else begin
        hold <= 0;
        hold_done = 1;
      end
    end
  end

  int ready_mode = 0;
  int mode_cycles = 0;

  always @(negedge clk) begin
    logic r;
    if (mode_cycles == 0) begin
      ready_mode  = $urandom_range(0, 2);
      mode_cycles = $urandom_range(16, 200);
    end else mode_cycles--;
    case (ready_mode)
      0:       r = 1;
      1:       r = $urandom_range(0, 1);
      default: r = ($urandom_range(0, 3) == 0);
    endcase
    m_tready <= r && !hold && !rst;
  end

  // ---------------------------------------------------------------- stimulus

  function automatic job_t tile_write(int idx, int code);
    job_t j;
    j.kind = K_ITEM;
    j.op   = tmbc_pkg::OP_WRITE;
    j.data = {3'b000, 9'($urandom), 8'($urandom), 8'($urandom), 9'($urandom),
              9'($urandom), 8'(code), 10'(idx)};
    return j;
  endfunction

  function automatic job_t box_query(int bx, int by, int bw, int bh, int py);
    job_t j;
    j.kind = K_ITEM;
    j.op   = tmbc_pkg::OP_QUERY;
    j.data = {3'b000, 9'(py), 8'(bh), 8'(bw), 9'(by), 9'(bx), 8'($urandom), 10'($urandom)};
    return j;
  endfunction

  task automatic set_registers(int cols, int rows, int sf, int sl, int pf, int pl,
                               int df, int dl);
    job_t j;
    int vals [8];
    vals = '{cols, rows, sf, sl, pf, pl, df, dl};
    j.kind = K_SETTLE;
    jobs.push_back(j);
    for (int i = 0; i < 8; i++) begin
      j.kind = K_CFG;
      j.ridx = 4'(i);
      j.rval = 8'(vals[i]);
      jobs.push_back(j);
    end
  endtask

  task automatic random_items(int n, int cols, int rows);
    int px, py0, bw, bh;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 3) jobs.push_back(tile_write($urandom, $urandom));
      else begin
        // mostly small boxes inside or near the map, now and then anything
        if ($urandom_range(0, 7) == 0) begin
          jobs.push_back(box_query($urandom, $urandom, $urandom_range(0, 255),
                                   $urandom_range(0, 255), $urandom));
        end else begin
          px  = cols * tmbc_pkg::TILE_PIXELS + 16;
          py0 = rows * tmbc_pkg::TILE_PIXELS + 16;
          bw  = $urandom_range(1, 24);
          bh  = $urandom_range(1, 24);
          jobs.push_back(box_query($urandom_range(0, px), $urandom_range(0, py0), bw, bh,
                                   $urandom_range(0, py0)));
        end
      end
    end
  endtask

  initial begin
    job_t j;
    for (int i = 0; i < 8; i++) regs[i] = 8'd0;
    regs[tmbc_pkg::REG_MAP_COLUMNS] = 8'd32;
    regs[tmbc_pkg::REG_MAP_ROWS]    = 8'd32;

    // preload the whole store so no query reads an unwritten tile
    for (int i = 0; i < tmbc_pkg::STORE_DEPTH; i++)
      jobs.push_back(tile_write(i, ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 255)));

    // reset defaults: code zero is solid, platform and side
    jobs.push_back(box_query(0, 0, 1, 1, 0));
    jobs.push_back(box_query(40, 40, 16, 16, 60));

    set_registers(32, 32, 180, 255, 100, 140, 60, 99);
    jobs.push_back(tile_write(1023, 255));
    jobs.push_back(tile_write(0, 0));
    jobs.push_back(tile_write(513, 200));
    jobs.push_back(box_query(0, 0, 1, 1, 0));
    jobs.push_back(box_query(511, 511, 255, 255, 511));
    jobs.push_back(box_query(0, 0, 255, 255, 511));
    jobs.push_back(box_query(511, 0, 1, 1, 0));
    jobs.push_back(box_query(0, 511, 1, 255, 511));
    jobs.push_back(box_query(64, 64, 0, 0, 64));         // zero sizes
    jobs.push_back(box_query(8, 8, 8, 200, 20));         // ceiling row above the top
    jobs.push_back(box_query(8, 8, 8, 255, 0));          // negative ceiling sum
    jobs.push_back(box_query(248, 100, 8, 8, 108));      // right edge column of the map
    jobs.push_back(box_query(80, 72, 24, 24, 96));
    jobs.push_back(box_query(300, 300, 10, 10, 310));    // outside the map
    random_items(RANDOM_ITEMS / 4, 32, 32);

    set_registers(1, 1, 0, 255, 0, 0, 0, 255);           // smallest map, full solid and side ranges
    jobs.push_back(box_query(0, 0, 8, 8, 7));
    jobs.push_back(box_query(4, 4, 20, 20, 30));
    random_items(RANDOM_ITEMS / 8, 1, 1);

    set_registers(7, 5, 200, 100, 255, 0, 255, 255);     // empty solid and platform ranges
    random_items(RANDOM_ITEMS / 8, 7, 5);

    set_registers(13, 32, 0, 127, 128, 255, 0, 0);
    random_items(RANDOM_ITEMS / 4, 13, 32);

    set_registers(32, 19, 150, 255, 90, 149, 30, 89);
    random_items(RANDOM_ITEMS / 4, 32, 19);

    repeat (2) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    wait (jobs.size() == 0 && pending_reports.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("tb_tile_map_box_collision_unit: PASS");
    end else begin
      $display("tb_tile_map_box_collision_unit: FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/tmbc_pkg.sv
rtl/core/tmbc_ram.sv
rtl/core/tile_map_box_collision_unit.sv
dv/tb_tile_map_box_collision_unit.sv
